>>> rtl/core/rfbu_pkg.sv
// Shared types and codes for the regula falsi bracket update block.
`default_nettype none

package rfbu_pkg;

  typedef enum logic [1:0] {
    MODE_ANDERSON = 2'd0,
    MODE_PEGASUS  = 2'd1,
    MODE_ILLINOIS = 2'd2,
    MODE_PLAIN    = 2'd3
  } method_e;

  localparam int unsigned MODE_W = 2;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  typedef enum logic {
    OP_DIV = 1'b0,
    OP_MUL = 1'b1
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/rfbu_arith_unit.sv
// Shared shift and add/subtract unit for fraction division and scaling.
`default_nettype none

module rfbu_arith_unit #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  rfbu_pkg::arith_req_t      req_i,
  input  wire  [DATA_WIDTH:0]       num_i,
  input  wire  [DATA_WIDTH:0]       den_i,
  input  wire  [FRAC_BITS:0]        gamma_i,
  output rfbu_pkg::arith_stat_t     stat_o,
  output logic [FRAC_BITS-1:0]      quot_o,
  output logic [DATA_WIDTH-1:0]     prod_o
);

  localparam int unsigned AW = DATA_WIDTH + FRAC_BITS + 1;
  localparam int unsigned CW = $clog2(FRAC_BITS + 2);

  logic                  busy_q;
  logic                  done_q;
  logic [CW-1:0]         cnt_q;
  rfbu_pkg::arith_op_e   op_q;
  logic [AW-1:0]         acc_q;
  logic [AW-1:0]         acc_d;
  logic [DATA_WIDTH:0]   aux_q;
  logic [FRAC_BITS:0]    bits_q;
  logic [FRAC_BITS:0]    bits_d;

  logic [AW-1:0]         two_w;
  logic [AW-1:0]         add_b;
  logic                  sub_w;
  logic [AW:0]           sum_w;
  logic                  ge_w;

  assign two_w = {acc_q[AW-2:0], 1'b0};
  assign sub_w = (op_q == rfbu_pkg::OP_DIV);

  always_comb begin
    if (sub_w || bits_q[FRAC_BITS]) begin
      add_b = {{(AW-DATA_WIDTH-1){1'b0}}, aux_q};
    end else begin
      add_b = '0;
    end
  end

  assign sum_w = {1'b0, two_w} + {1'b0, add_b ^ {AW{sub_w}}} + {{AW{1'b0}}, sub_w};
  assign ge_w  = sum_w[AW];

  always_comb begin
    if (sub_w) begin
      acc_d  = ge_w ? sum_w[AW-1:0] : two_w;
      bits_d = {bits_q[FRAC_BITS-1:0], ge_w};
    end else begin
      acc_d  = sum_w[AW-1:0];
      bits_d = {bits_q[FRAC_BITS-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        if (req_i.op == rfbu_pkg::OP_DIV) begin
          cnt_q <= CW'(FRAC_BITS - 1);
        end else begin
          cnt_q <= CW'(FRAC_BITS);
        end
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      op_q <= req_i.op;
      if (req_i.op == rfbu_pkg::OP_DIV) begin
        acc_q  <= {{(AW-DATA_WIDTH-1){1'b0}}, num_i};
        aux_q  <= den_i;
        bits_q <= '0;
      end else begin
        acc_q  <= '0;
        aux_q  <= num_i;
        bits_q <= gamma_i;
      end
    end else if (busy_q) begin
      acc_q  <= acc_d;
      bits_q <= bits_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = bits_q[FRAC_BITS-1:0];
  assign prod_o      = acc_q[FRAC_BITS +: DATA_WIDTH];

endmodule

`default_nettype wire

>>> rtl/core/regula_falsi_bracket_update.sv
// Top level of the regula falsi bracket keeper with sequencer and bracket registers.
//
// The input channel carries one request: func_i selects a load of the initial
// bracket or an update with a query time and value. The result channel returns
// the bracket after each request with sign_error_o. Both channels use valid
// and stall; the sink drives stall. The configuration channel writes the
// two-bit method mode with valid and ready and is always ready.
// A load or an update whose query crosses the sign goes straight to the finish
// state. A scaling update runs a multiplication in the shared unit, preceded
// by a division when Anderson-Bjorck or Pegasus needs a quotient. The
// shared add/subtract unit produces one quotient or multiplier bit per cycle.
// One request is in work at a time; in_stall_o is high until its result has
// been placed in the output register, which then holds it while the receiver
// stalls. A new request is taken while that result still waits.
// Reset clears the bracket to zero, the mode to Anderson-Bjorck and the
// output register to empty.
`default_nettype none

module regula_falsi_bracket_update #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          func_i,
  input  wire  signed [DATA_WIDTH-1:0] init_time_first_i,
  input  wire  signed [DATA_WIDTH-1:0] init_time_second_i,
  input  wire  signed [DATA_WIDTH-1:0] init_value_first_i,
  input  wire  signed [DATA_WIDTH-1:0] init_value_second_i,
  input  wire  signed [DATA_WIDTH-1:0] query_time_i,
  input  wire  signed [DATA_WIDTH-1:0] query_value_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic signed [DATA_WIDTH-1:0] bracket_time_first_o,
  output logic signed [DATA_WIDTH-1:0] bracket_time_second_o,
  output logic signed [DATA_WIDTH-1:0] bracket_value_first_o,
  output logic signed [DATA_WIDTH-1:0] bracket_value_second_o,
  output logic                         sign_error_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [rfbu_pkg::MODE_W-1:0]  cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [FRAC_BITS:0] GAMMA_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0] GAMMA_HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};
  localparam logic [FRAC_BITS:0] GAMMA_ZERO = '0;

  logic [1:0]              state_q, state_d;
  rfbu_pkg::method_e       mode_q;
  logic [DATA_WIDTH-1:0]   tf_q, tf_d;
  logic [DATA_WIDTH-1:0]   ts_q, ts_d;
  logic [DATA_WIDTH-1:0]   vf_q, vf_d;
  logic [DATA_WIDTH-1:0]   vs_q, vs_d;
  logic                    err_q, err_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_load;
  logic [DATA_WIDTH-1:0]   out_tf_q, out_ts_q, out_vf_q, out_vs_q;
  logic                    out_err_q;

  logic [DATA_WIDTH-1:0]   a1_w, aq_w, as_w;
  logic [DATA_WIDTH:0]   sum_w;
  logic                    opposite_w;
  logic                    init_bad_w;

  rfbu_pkg::arith_req_t    req_w;
  rfbu_pkg::arith_stat_t   stat_w;
  logic [DATA_WIDTH:0]     num_w, den_w;
  logic [FRAC_BITS:0]      gam_w;
  logic [FRAC_BITS-1:0]    quot_w;
  logic [DATA_WIDTH-1:0]   prod_w;

  assign a1_w  = vf_q[DATA_WIDTH-1] ? (~vf_q + 1'b1) : vf_q;
  assign aq_w  = query_value_i[DATA_WIDTH-1] ? (~query_value_i + 1'b1) : query_value_i;
  assign as_w  = vs_q[DATA_WIDTH-1] ? (~vs_q + 1'b1) : vs_q;
  assign sum_w = {1'b0, a1_w} + {1'b0, aq_w};

  assign opposite_w = (query_value_i != '0) && (vf_q != '0) &&
                      (query_value_i[DATA_WIDTH-1] != vf_q[DATA_WIDTH-1]);
  assign init_bad_w = (init_value_first_i != '0) && (init_value_second_i != '0) &&
                      (init_value_first_i[DATA_WIDTH-1] == init_value_second_i[DATA_WIDTH-1]);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d   = state_q;
    tf_d      = tf_q;
    ts_d      = ts_q;
    vf_d      = vf_q;
    vs_d      = vs_q;
    err_d     = err_q;
    req_w     = '{start: 1'b0, op: rfbu_pkg::OP_DIV};
    num_w     = '0;
    den_w     = '0;
    gam_w     = GAMMA_ONE;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (func_i == rfbu_pkg::FUNC_LOAD) begin
            state_d = ST_FIN;
            if (init_bad_w) begin
              err_d = 1'b1;
            end else begin
              err_d = 1'b0;
              tf_d  = init_time_first_i;
              ts_d  = init_time_second_i;
              vf_d  = init_value_first_i;
              vs_d  = init_value_second_i;
            end
          end else begin
            err_d = 1'b0;
            tf_d  = query_time_i;
            vf_d  = query_value_i;
            if (opposite_w) begin
              ts_d    = tf_q;
              vs_d    = vf_q;
              state_d = ST_FIN;
            end else begin
              req_w.start = 1'b1;
              req_w.op    = rfbu_pkg::OP_MUL;
              num_w       = {1'b0, as_w};
              state_d     = ST_MUL;
              unique case (mode_q)
                rfbu_pkg::MODE_ANDERSON: begin
                  if ((a1_w == '0) || (aq_w > a1_w)) begin
                    gam_w = GAMMA_HALF;
                  end else if (aq_w == a1_w) begin
                    gam_w = GAMMA_ZERO;
                  end else begin
                    req_w.op = rfbu_pkg::OP_DIV;
                    num_w    = {1'b0, aq_w};
                    den_w    = {1'b0, a1_w};
                    state_d  = ST_DIV;
                  end
                end
                rfbu_pkg::MODE_PEGASUS: begin
                  if (aq_w == '0) begin
                    gam_w = GAMMA_ONE;
                  end else if (aq_w == a1_w) begin
                    gam_w = GAMMA_HALF;
                  end else begin
                    req_w.op = rfbu_pkg::OP_DIV;
                    num_w    = {1'b0, a1_w};
                    den_w    = sum_w;
                    state_d  = ST_DIV;
                  end
                end
                rfbu_pkg::MODE_ILLINOIS: gam_w = GAMMA_HALF;
                rfbu_pkg::MODE_PLAIN:    gam_w = GAMMA_ONE;
                default:                 gam_w = GAMMA_ONE;
              endcase
            end
          end
        end
      end
      ST_DIV: begin
        if (stat_w.done) begin
          req_w.start = 1'b1;
          req_w.op    = rfbu_pkg::OP_MUL;
          num_w       = {1'b0, as_w};
          if (mode_q == rfbu_pkg::MODE_ANDERSON) begin
            gam_w = GAMMA_ONE - {1'b0, quot_w};
          end else begin
            gam_w = {1'b0, quot_w};
          end
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (stat_w.done) begin
          vs_d    = vs_q[DATA_WIDTH-1] ? (~prod_w + 1'b1) : prod_w;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  rfbu_arith_unit #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_w),
    .num_i   (num_w),
    .den_i   (den_w),
    .gamma_i (gam_w),
    .stat_o  (stat_w),
    .quot_o  (quot_w),
    .prod_o  (prod_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= rfbu_pkg::MODE_ANDERSON;
      tf_q        <= '0;
      ts_q        <= '0;
      vf_q        <= '0;
      vs_q        <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tf_q        <= tf_d;
      ts_q        <= ts_d;
      vf_q        <= vf_d;
      vs_q        <= vs_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= rfbu_pkg::method_e'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_tf_q  <= tf_q;
      out_ts_q  <= ts_q;
      out_vf_q  <= vf_q;
      out_vs_q  <= vs_q;
      out_err_q <= err_q;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign bracket_time_first_o   = out_tf_q;
  assign bracket_time_second_o  = out_ts_q;
  assign bracket_value_first_o  = out_vf_q;
  assign bracket_value_second_o = out_vs_q;
  assign sign_error_o           = out_err_q;

endmodule

`default_nettype wire
